/* src/rtip_pkg.sv */
`timescale 1ns / 1ps

package rtip_pkg;

  // default widths of the result word and the position counter
  localparam int WORD_BITS_DEF = 32;
  localparam int POS_BITS_DEF  = 16;

  // configuration port
  localparam int RADIX_BITS   = 6;
  localparam int CFG_IDX_BITS = 1;
  localparam int CFG_DATA_BITS = RADIX_BITS;

  localparam logic [CFG_IDX_BITS-1:0] CFG_RADIX       = 1'd0;
  localparam logic [CFG_IDX_BITS-1:0] CFG_SIGNED_MODE = 1'd1;

  localparam logic [RADIX_BITS-1:0] RADIX_RESET       = 6'd10;
  localparam logic                  SIGNED_MODE_RESET = 1'b1;

  // bases that the prefix logic picks
  localparam logic [RADIX_BITS-1:0] BASE_DEC = 6'd10;
  localparam logic [RADIX_BITS-1:0] BASE_OCT = 6'd8;
  localparam logic [RADIX_BITS-1:0] BASE_HEX = 6'd16;
  localparam logic [RADIX_BITS-1:0] BASE_AUTO = 6'd0;

  // characters
  localparam logic [7:0] CH_SPACE = 8'h20;
  localparam logic [7:0] CH_TAB   = 8'h09;
  localparam logic [7:0] CH_CR    = 8'h0D;
  localparam logic [7:0] CH_PLUS  = 8'h2B;
  localparam logic [7:0] CH_MINUS = 8'h2D;
  localparam logic [7:0] CH_ZERO  = 8'h30;
  localparam logic [7:0] CH_NINE  = 8'h39;
  localparam logic [7:0] CH_UA    = 8'h41;
  localparam logic [7:0] CH_UZ    = 8'h5A;
  localparam logic [7:0] CH_LA    = 8'h61;
  localparam logic [7:0] CH_LZ    = 8'h7A;
  localparam logic [7:0] CH_UX    = 8'h58;
  localparam logic [7:0] CH_LX    = 8'h78;
  localparam logic [7:0] UPPER_OFS = 8'd55;  // 'A' - 10
  localparam logic [7:0] LOWER_OFS = 8'd87;  // 'a' - 10

  // digit value of one character
  typedef struct packed {
    logic                  ok;
    logic [RADIX_BITS-1:0] val;
  } digit_t;

  function automatic digit_t char_digit(input logic [7:0] c);
    digit_t d;
    logic [7:0] t;
    d.ok  = 1'b0;
    d.val = '0;
    t     = '0;
    if (c >= CH_ZERO && c <= CH_NINE) begin
      t = c - CH_ZERO;
      d.ok = 1'b1;
    end else if (c >= CH_UA && c <= CH_UZ) begin
      t = c - UPPER_OFS;
      d.ok = 1'b1;
    end else if (c >= CH_LA && c <= CH_LZ) begin
      t = c - LOWER_OFS;
      d.ok = 1'b1;
    end
    d.val = t[RADIX_BITS-1:0];
    return d;
  endfunction

endpackage

/* src/radix_text_integer_parser_top.sv */
`timescale 1ns / 1ps

// text integer parser, one character beat per cycle unless the result side stalls
// a character is captured in the input register, parsed from there, and its result is held in the result register
// throughput: one character per cycle while the result register is not stalled; the digit step is one multiply-add
// and compare into the accumulator, done between the input register and the result register
// reset: synchronous active-low rst_n empties both registers, parser idle,
// radix 10 and signed mode on
module radix_text_integer_parser_top #(
  parameter int WORD_BITS = rtip_pkg::WORD_BITS_DEF,
  parameter int POS_BITS  = rtip_pkg::POS_BITS_DEF
) (
  input  logic                              clk,
  input  logic                              rst_n,
  // configuration
  input  logic                              cfg_valid,
  output logic                              cfg_ready,
  input  logic [rtip_pkg::CFG_IDX_BITS-1:0] cfg_index,
  input  logic [rtip_pkg::CFG_DATA_BITS-1:0] cfg_data,
  // characters in
  input  logic                              in_valid,
  output logic                              in_stall,
  input  logic [7:0]                        in_ch,
  input  logic                              in_first,
  // results out
  output logic                              out_valid,
  input  logic                              out_stall,
  output logic [WORD_BITS-1:0]              out_value,
  output logic                              out_had_digits,
  output logic                              out_overflowed,
  output logic [POS_BITS-1:0]               out_end_offset
);

  localparam int RB = rtip_pkg::RADIX_BITS;
  localparam int PW = WORD_BITS + RB + 1;
  localparam logic [WORD_BITS-1:0] WHALF = {1'b1, {(WORD_BITS-1){1'b0}}};
  localparam logic [WORD_BITS-1:0] WMAX  = {WORD_BITS{1'b1}};
  localparam logic [POS_BITS-1:0]  PMAX  = {POS_BITS{1'b1}};

  typedef enum logic [2:0] {
    PH_IDLE,
    PH_LEAD,
    PH_SIGNED,
    PH_ZERO,
    PH_DIGITS
  } phase_t;

  // configuration registers
  logic [RB-1:0] radix_r;
  logic          signed_mode_r;

  // input register
  logic       in_valid_r;
  logic [7:0] ch_r;
  logic       first_r;

  // parser state
  phase_t               phase_r, phase_nxt;
  logic [WORD_BITS-1:0] acc_r, acc_nxt;
  logic                 neg_r, neg_nxt;
  logic [RB-1:0]        base_r, base_nxt;
  logic                 ds_r, ds_nxt;
  logic                 ovf_r, ovf_nxt;
  logic [POS_BITS-1:0]  pos_r, pos_nxt;

  // result register
  logic                 out_valid_r;
  logic [WORD_BITS-1:0] value_r, value_nxt;
  logic                 had_digits_r, had_digits_nxt;
  logic                 overflowed_r, overflowed_nxt;
  logic [POS_BITS-1:0]  end_offset_r, end_offset_nxt;

  logic out_free;
  logic proc_go;
  logic emit;

  // view of the state this character sees
  phase_t               cur_phase;
  logic [WORD_BITS-1:0] cur_acc;
  logic                 cur_neg;
  logic [RB-1:0]        cur_base;
  logic                 cur_ds;
  logic                 cur_ovf;
  logic [POS_BITS-1:0]  cur_pos;

  logic                 start;
  logic                 do_digit;
  logic [RB-1:0]        base_d;
  logic                 ds_in;
  rtip_pkg::digit_t     dig;
  logic [WORD_BITS-1:0] limit;
  logic [PW-1:0]        prod;
  logic                 is_space;

  assign cfg_ready = 1'b1;

  // handshake between the two registers
  assign out_free = !out_valid_r || !out_stall;
  assign proc_go  = in_valid_r && out_free;
  assign in_stall = in_valid_r && !out_free;

  assign out_valid      = out_valid_r;
  assign out_value      = value_r;
  assign out_had_digits = had_digits_r;
  assign out_overflowed = overflowed_r;
  assign out_end_offset = end_offset_r;

  // one character step
  always_comb begin
    // a first-marked character restarts the parse
    if (first_r) begin
      cur_phase = PH_LEAD;
      cur_acc   = '0;
      cur_neg   = 1'b0;
      cur_base  = radix_r;
      cur_ds    = 1'b0;
      cur_ovf   = 1'b0;
      cur_pos   = '0;
    end else begin
      cur_phase = phase_r;
      cur_acc   = acc_r;
      cur_neg   = neg_r;
      cur_base  = base_r;
      cur_ds    = ds_r;
      cur_ovf   = ovf_r;
      cur_pos   = pos_r;
    end

    phase_nxt = cur_phase;
    acc_nxt   = cur_acc;
    neg_nxt   = cur_neg;
    base_nxt  = cur_base;
    ds_nxt    = cur_ds;
    ovf_nxt   = cur_ovf;
    pos_nxt   = cur_pos;
    emit      = 1'b0;
    start     = 1'b0;
    do_digit  = 1'b0;
    base_d    = (cur_base == rtip_pkg::BASE_AUTO) ? rtip_pkg::BASE_DEC : cur_base;
    ds_in     = cur_ds;
    dig       = rtip_pkg::char_digit(ch_r);
    is_space  = (ch_r == rtip_pkg::CH_SPACE) ||
                (ch_r >= rtip_pkg::CH_TAB && ch_r <= rtip_pkg::CH_CR);

    unique case (cur_phase)
      PH_IDLE: begin
      end
      PH_LEAD: begin
        if (is_space) begin
        end else if (ch_r == rtip_pkg::CH_MINUS) begin
          neg_nxt   = 1'b1;
          phase_nxt = PH_SIGNED;
        end else if (ch_r == rtip_pkg::CH_PLUS) begin
          phase_nxt = PH_SIGNED;
        end else begin
          start = 1'b1;
        end
      end
      PH_SIGNED: begin
        start = 1'b1;
      end
      PH_ZERO: begin
        if (ch_r == rtip_pkg::CH_LX || ch_r == rtip_pkg::CH_UX) begin
          base_nxt  = rtip_pkg::BASE_HEX;
          phase_nxt = PH_DIGITS;
        end else begin
          // the held zero counts as a digit, then this character is taken as a digit or ends the number
          base_d    = (cur_base == rtip_pkg::BASE_AUTO) ? rtip_pkg::BASE_OCT : cur_base;
          ds_in     = 1'b1;
          do_digit  = 1'b1;
          phase_nxt = PH_DIGITS;
        end
      end
      PH_DIGITS: begin
        do_digit = 1'b1;
      end
      default: begin
      end
    endcase

    // first character after whitespace and sign
    if (start) begin
      if (ch_r == rtip_pkg::CH_ZERO &&
          (cur_base == rtip_pkg::BASE_AUTO || cur_base == rtip_pkg::BASE_HEX)) begin
        phase_nxt = PH_ZERO;
      end else begin
        do_digit  = 1'b1;
        phase_nxt = PH_DIGITS;
      end
    end

    // saturation limit, sign mode read live
    if (signed_mode_r) begin
      limit = cur_neg ? WHALF : WHALF - WORD_BITS'(1);
    end else begin
      limit = WMAX;
    end

    // multiply-add; over the limit means overflow
    prod = PW'(cur_acc) * PW'(base_d) + PW'(dig.val);

    if (do_digit) begin
      base_nxt = base_d;
      ds_nxt   = ds_in;
      if (!dig.ok || dig.val >= base_d) begin
        emit      = 1'b1;
        phase_nxt = PH_IDLE;
      end else begin
        ds_nxt = 1'b1;
        if (cur_ovf || prod > PW'(limit)) begin
          ovf_nxt = 1'b1;
        end else begin
          acc_nxt = prod[WORD_BITS-1:0];
        end
      end
    end

    // saturating character position
    if (cur_phase != PH_IDLE && cur_pos != PMAX) begin
      pos_nxt = cur_pos + POS_BITS'(1);
    end

    // result of an ending character
    if (cur_ovf) begin
      value_nxt = limit;
    end else if (cur_neg) begin
      value_nxt = WORD_BITS'(0) - cur_acc;
    end else begin
      value_nxt = cur_acc;
    end
    had_digits_nxt = ds_in;
    overflowed_nxt = cur_ovf;
    end_offset_nxt = ds_in ? cur_pos : '0;
  end

  // state, input register and result register
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      radix_r       <= rtip_pkg::RADIX_RESET;
      signed_mode_r <= rtip_pkg::SIGNED_MODE_RESET;
      in_valid_r    <= 1'b0;
      out_valid_r   <= 1'b0;
      phase_r       <= PH_IDLE;
      acc_r         <= '0;
      neg_r         <= 1'b0;
      base_r        <= '0;
      ds_r          <= 1'b0;
      ovf_r         <= 1'b0;
      pos_r         <= '0;
    end else begin
      // configuration writes
      if (cfg_valid) begin
        unique case (cfg_index)
          rtip_pkg::CFG_RADIX:       radix_r       <= cfg_data;
          rtip_pkg::CFG_SIGNED_MODE: signed_mode_r <= cfg_data[0];
          default: begin
          end
        endcase
      end

      // input beat
      if (!in_stall) begin
        in_valid_r <= in_valid;
        ch_r       <= in_ch;
        first_r    <= in_first;
      end

      // parse step
      if (proc_go) begin
        phase_r <= phase_nxt;
        acc_r   <= acc_nxt;
        neg_r   <= neg_nxt;
        base_r  <= base_nxt;
        ds_r    <= ds_nxt;
        ovf_r   <= ovf_nxt;
        pos_r   <= pos_nxt;
      end

      // result beat
      if (proc_go && emit) begin
        out_valid_r  <= 1'b1;
        value_r      <= value_nxt;
        had_digits_r <= had_digits_nxt;
        overflowed_r <= overflowed_nxt;
        end_offset_r <= end_offset_nxt;
      end else if (!out_stall) begin
        out_valid_r <= 1'b0;
      end
    end
  end

endmodule

/* tb/tb_top.sv */
`timescale 1ns / 1ps

module tb_top;

  localparam int CYCLE_LIMIT = 800000;
  localparam int HOLD_CYCLES = 300;
  localparam int SETTLE_CYCLES = 4;

  typedef enum logic [2:0] {
    SCAN_IDLE,
    SCAN_LEAD,
    SCAN_SIGN,
    SCAN_ZERO,
    SCAN_DIGITS
  } scan_phase_t;

  typedef struct packed {
    logic [7:0] ch;
    logic       first;
  } char_beat_t;

  typedef struct packed {
    logic [31:0] value;
    logic        had_digits;
    logic        overflowed;
    logic [15:0] end_offset;
  } number_t;

  logic clk;
  logic rst_n = 1'b0;

  logic                               cfg_valid = 1'b0;
  logic                               cfg_ready;
  logic [rtip_pkg::CFG_IDX_BITS-1:0]  cfg_index = '0;
  logic [rtip_pkg::CFG_DATA_BITS-1:0] cfg_data = '0;
  logic                               in_valid = 1'b0;
  logic                               in_stall;
  logic [7:0]                         in_ch = '0;
  logic                               in_first = 1'b0;
  logic                               out_valid;
  logic                               out_stall = 1'b0;
  logic [31:0]                        out_value;
  logic                               out_had_digits;
  logic                               out_overflowed;
  logic [15:0]                        out_end_offset;

  radix_text_integer_parser_top DUT (
    .clk            (clk),
    .rst_n          (rst_n),
    .cfg_valid      (cfg_valid),
    .cfg_ready      (cfg_ready),
    .cfg_index      (cfg_index),
    .cfg_data       (cfg_data),
    .in_valid       (in_valid),
    .in_stall       (in_stall),
    .in_ch          (in_ch),
    .in_first       (in_first),
    .out_valid      (out_valid),
    .out_stall      (out_stall),
    .out_value      (out_value),
    .out_had_digits (out_had_digits),
    .out_overflowed (out_overflowed),
    .out_end_offset (out_end_offset)
  );

  // character beats waiting to be sent, numbers the scanner has closed
  char_beat_t char_queue[$];
  number_t    parsed_numbers[$];
  char_beat_t beat;

  // scanner copy of the block state and registers
  scan_phase_t scan_phase;
  logic [63:0] acc;
  logic        neg;
  logic        seen_digit;
  logic        seen_ovf;
  logic [5:0]  base_lat;
  logic [15:0] pos;
  logic [5:0]  radix_reg;
  logic        signed_reg;

  int   chars_accepted = 0;
  int   numbers_seen = 0;
  int   mismatch_count = 0;
  int   queued_chars = 0;
  int   settings_used = 1;
  int   send_gap = 0;
  int   recv_gap = 0;
  int   cycle_count = 0;
  int   hold_requests = 0;
  int   holds_served = 0;
  int   hold_left = 0;
  logic steady = 1'b0;
  logic mark_first = 1'b0;

  initial begin
    clk = 1'b0;
    forever #2 clk = ~clk;
  end

  // ---------------------------------------------------------------
  // scanner: strtol / strtoul rules, one character at a time
  // ---------------------------------------------------------------

  function automatic int digit_value(input logic [7:0] c);
    if (c >= rtip_pkg::CH_ZERO && c <= rtip_pkg::CH_NINE) return int'(c - rtip_pkg::CH_ZERO);
    if (c >= rtip_pkg::CH_UA && c <= rtip_pkg::CH_UZ) return int'(c - rtip_pkg::CH_UA) + 10;
    if (c >= rtip_pkg::CH_LA && c <= rtip_pkg::CH_LZ) return int'(c - rtip_pkg::CH_LA) + 10;
    return -1;
  endfunction

  function automatic logic [63:0] cur_base();
    return (base_lat != rtip_pkg::BASE_AUTO) ? 64'(base_lat) : 64'(rtip_pkg::BASE_DEC);
  endfunction

  // magnitude bound for the current sign and mode
  function automatic logic [63:0] number_limit();
    if (!signed_reg) return 64'hFFFF_FFFF;
    return neg ? 64'h8000_0000 : 64'h7FFF_FFFF;
  endfunction

  task automatic reset_scanner();
    scan_phase = SCAN_IDLE;
    acc = '0;
    neg = 1'b0;
    base_lat = '0;
    seen_digit = 1'b0;
    seen_ovf = 1'b0;
    pos = '0;
    radix_reg = rtip_pkg::RADIX_RESET;
    signed_reg = rtip_pkg::SIGNED_MODE_RESET;
  endtask

  task automatic add_digit(input int d);
    logic [63:0] b;
    logic [63:0] lim;
    b = cur_base();
    lim = number_limit();
    seen_digit = 1'b1;
    if (seen_ovf || acc > lim / b || (acc == lim / b && d > lim % b))
      seen_ovf = 1'b1;
    else
      acc = acc * b + d;
  endtask

  task automatic close_number();
    number_t n;
    logic [63:0] lim;
    lim = number_limit();
    if (seen_ovf)
      n.value = lim[31:0];
    else if (neg)
      n.value = ~acc[31:0] + 32'd1;
    else
      n.value = acc[31:0];
    n.had_digits = seen_digit;
    n.overflowed = seen_ovf;
    n.end_offset = seen_digit ? pos : 16'd0;
    parsed_numbers.push_back(n);
    scan_phase = SCAN_IDLE;
  endtask

  task automatic take_digit(input logic [7:0] c);
    int d;
    d = digit_value(c);
    if (d < 0 || d >= cur_base())
      close_number();
    else
      add_digit(d);
  endtask

  task automatic open_number(input logic [7:0] c);
    if (c == rtip_pkg::CH_ZERO &&
        (base_lat == rtip_pkg::BASE_AUTO || base_lat == rtip_pkg::BASE_HEX)) begin
      scan_phase = SCAN_ZERO;
    end else begin
      if (base_lat == rtip_pkg::BASE_AUTO) base_lat = rtip_pkg::BASE_DEC;
      scan_phase = SCAN_DIGITS;
      take_digit(c);
    end
  endtask

  task automatic scan_char(input logic [7:0] c, input logic first);
    if (first) begin
      acc = '0;
      neg = 1'b0;
      seen_digit = 1'b0;
      seen_ovf = 1'b0;
      pos = '0;
      base_lat = radix_reg;
      scan_phase = SCAN_LEAD;
    end
    if (scan_phase != SCAN_IDLE) begin
      case (scan_phase)
        SCAN_LEAD: begin
          if (c == rtip_pkg::CH_MINUS) begin
            neg = 1'b1;
            scan_phase = SCAN_SIGN;
          end else if (c == rtip_pkg::CH_PLUS) begin
            scan_phase = SCAN_SIGN;
          end else if (!(c == rtip_pkg::CH_SPACE ||
                         (c >= rtip_pkg::CH_TAB && c <= rtip_pkg::CH_CR))) begin
            open_number(c);
          end
        end
        SCAN_SIGN: open_number(c);
        SCAN_ZERO: begin
          if (c == rtip_pkg::CH_LX || c == rtip_pkg::CH_UX) begin
            base_lat = rtip_pkg::BASE_HEX;
            scan_phase = SCAN_DIGITS;
          end else begin
            // the held zero is a digit, octal when the radix was automatic
            if (base_lat == rtip_pkg::BASE_AUTO) base_lat = rtip_pkg::BASE_OCT;
            add_digit(0);
            scan_phase = SCAN_DIGITS;
            take_digit(c);
          end
        end
        default: take_digit(c);
      endcase
      if (pos != 16'hFFFF) pos++;
    end
  endtask

  // mostly short gaps, a few long ones, none in steady phases
  function automatic int pick_gap();
    int r;
    if (steady) return 0;
    r = $urandom_range(0, 99);
    if (r < 55) return 0;
    if (r < 90) return $urandom_range(1, 3);
    return $urandom_range(4, 40);
  endfunction

  // ---------------------------------------------------------------
  // driver: character beats from the queue, scanned on acceptance
  // ---------------------------------------------------------------
  always @(posedge clk) begin
    if (!rst_n) begin
      in_valid <= 1'b0;
      in_ch <= '0;
      in_first <= 1'b0;
      send_gap = 0;
      reset_scanner();
    end else begin
      if (in_valid && !in_stall) begin
        scan_char(in_ch, in_first);
        chars_accepted++;
      end
      if (!in_valid || !in_stall) begin
        if (send_gap > 0) begin
          send_gap--;
          in_valid <= 1'b0;
        end else if (char_queue.size() != 0) begin
          beat = char_queue.pop_front();
          in_valid <= 1'b1;
          in_ch <= beat.ch;
          in_first <= beat.first;
          send_gap = pick_gap();
        end else begin
          in_valid <= 1'b0;
        end
      end
    end
  end

  // ---------------------------------------------------------------
  // long receiver hold-off, counted here
  // ---------------------------------------------------------------
  always @(posedge clk) begin
    if (!rst_n) begin
      hold_left <= 0;
      holds_served <= 0;
    end else if (hold_left != 0) begin
      hold_left <= hold_left - 1;
    end else if (holds_served != hold_requests) begin
      hold_left <= HOLD_CYCLES;
      holds_served <= holds_served + 1;
    end
  end

  // ---------------------------------------------------------------
  // monitor: compare each result beat with the oldest parsed number
  // ---------------------------------------------------------------
  task automatic report_mismatch(input string what, input number_t want, input number_t got);
    mismatch_count++;
    if (mismatch_count <= 10)
      $display("%0t %s: expected %h %b %b %0d, got %h %b %b %0d",
               $time, what, want.value, want.had_digits, want.overflowed, want.end_offset,
               got.value, got.had_digits, got.overflowed, got.end_offset);
  endtask

  task automatic check_number();
    number_t want;
    number_t got;
    got.value = out_value;
    got.had_digits = out_had_digits;
    got.overflowed = out_overflowed;
    got.end_offset = out_end_offset;
    numbers_seen++;
    if (parsed_numbers.size() == 0) begin
      report_mismatch("result with no number pending", '0, got);
    end else begin
      want = parsed_numbers.pop_front();
      if (got.value !== want.value || got.had_digits !== want.had_digits ||
          got.overflowed !== want.overflowed || got.end_offset !== want.end_offset)
        report_mismatch("result mismatch", want, got);
    end
  endtask

  always @(posedge clk) begin
    if (!rst_n) begin
      out_stall <= 1'b0;
      recv_gap = 0;
    end else begin
      if (out_valid && !out_stall) check_number();
      if (recv_gap > 0) recv_gap--;
      else recv_gap = pick_gap();
      out_stall <= (hold_left != 0) || (recv_gap != 0);
    end
  end

  // run limit
  always @(posedge clk) begin
    cycle_count++;
    if (cycle_count >= CYCLE_LIMIT) begin
      $display("run stopped at the cycle limit with %0d numbers pending", parsed_numbers.size());
      $display("FAILURE");
      $finish;
    end
  end

  // ---------------------------------------------------------------
  // stimulus helpers
  // ---------------------------------------------------------------
  task automatic push_ch(input logic [7:0] c);
    char_beat_t b;
    b.ch = c;
    b.first = mark_first;
    char_queue.push_back(b);
    mark_first = 1'b0;
    queued_chars++;
  endtask

  task automatic more_text(input string s);
    foreach (s[i]) push_ch(s[i]);
  endtask

  task automatic push_text(input string s);
    mark_first = 1'b1;
    more_text(s);
  endtask

  function automatic logic [7:0] glyph(input int d);
    if (d < 10) return rtip_pkg::CH_ZERO + 8'(d);
    if ($urandom_range(0, 1)) return rtip_pkg::CH_UA + 8'(d - 10);
    return rtip_pkg::CH_LA + 8'(d - 10);
  endfunction

  // values around the signed and unsigned limits, plus plain ones
  function automatic logic [63:0] pick_value();
    case ($urandom_range(0, 5))
      0: return 64'h7FFF_FFFF + $urandom_range(0, 2);
      1: return 64'hFFFF_FFFF + $urandom_range(0, 1);
      2: return 64'($urandom_range(0, 1000));
      3: return {32'($urandom), 32'($urandom)} >> $urandom_range(0, 63);
      default: return 64'($urandom);
    endcase
  endfunction

  // one number string: blanks, sign, prefix, digits, end character
  task automatic gen_number(input int r);
    int eb;
    int k;
    int digs[$];
    logic [63:0] v;
    logic [7:0] c;
    mark_first = 1'b1;
    if ($urandom_range(0, 3) == 0) begin
      repeat ($urandom_range(1, 3)) begin
        k = $urandom_range(0, 5);
        push_ch(k == 5 ? rtip_pkg::CH_SPACE : rtip_pkg::CH_TAB + 8'(k));
      end
    end
    k = $urandom_range(0, 3);
    if (k == 0) push_ch(rtip_pkg::CH_MINUS);
    else if (k == 1) push_ch(rtip_pkg::CH_PLUS);
    eb = (r == 0) ? 10 : r;
    if (r == 0 || r == 16) begin
      k = $urandom_range(0, 2);
      if (k == 0) begin
        push_ch(rtip_pkg::CH_ZERO);
        push_ch($urandom_range(0, 1) ? rtip_pkg::CH_LX : rtip_pkg::CH_UX);
        eb = 16;
      end else if (k == 1 && r == 0) begin
        push_ch(rtip_pkg::CH_ZERO);
        eb = 8;
      end
    end
    if (eb >= 2 && eb <= 36 && $urandom_range(0, 2) != 0) begin
      v = pick_value();
      do begin
        digs.push_front(int'(v % eb));
        v = v / eb;
      end while (v != 0);
    end else begin
      repeat ($urandom_range(1, 12)) digs.push_back($urandom_range(0, eb >= 36 ? 35 : eb - 1));
    end
    foreach (digs[i]) push_ch(glyph(digs[i]));
    // end character: sometimes missing, sometimes any byte
    k = $urandom_range(0, 9);
    if (k == 1 || k == 2) begin
      push_ch(8'($urandom_range(0, 255)));
    end else if (k > 2) begin
      do c = 8'($urandom_range(0, 255)); while (digit_value(c) >= 0);
      push_ch(c);
    end
    if ($urandom_range(0, 4) == 0)
      repeat ($urandom_range(1, 3)) push_ch(8'($urandom_range(0, 255)));
  endtask

  task automatic gen_noise();
    repeat ($urandom_range(1, 4)) begin
      mark_first = $urandom_range(0, 1);
      push_ch(8'($urandom_range(0, 255)));
    end
  endtask

  // wait for every beat sent and every number back, then let the pipe settle
  task automatic drain();
    do @(negedge clk); while (char_queue.size() != 0 || in_valid || parsed_numbers.size() != 0);
    repeat (SETTLE_CYCLES) @(negedge clk);
  endtask

  task automatic write_reg(input logic [rtip_pkg::CFG_IDX_BITS-1:0] idx, input logic [5:0] data);
    @(posedge clk);
    cfg_valid <= 1'b1;
    cfg_index <= idx;
    cfg_data <= data;
    do @(posedge clk); while (!cfg_ready);
    cfg_valid <= 1'b0;
    if (idx == rtip_pkg::CFG_RADIX) radix_reg = data;
    else signed_reg = data[0];
  endtask

  task automatic set_regs(input logic [5:0] r, input logic s);
    logic [4:0] pad;
    pad = 5'($urandom_range(0, 31));
    drain();
    write_reg(rtip_pkg::CFG_RADIX, r);
    write_reg(rtip_pkg::CFG_SIGNED_MODE, {pad, s});
    settings_used++;
    @(negedge clk);
  endtask

  // ---------------------------------------------------------------
  // main sequence
  // ---------------------------------------------------------------
  initial begin
    int rad_list[10];
    int sgn_list[10];
    int target;
    rad_list = '{0, 0, 16, 16, 10, 36, 63, 1, 2, 0};
    sgn_list = '{1, 0, 0, 1, 0, 1, 0, 1, 0, 1};
    rst_n = 1'b0;
    repeat (5) @(posedge clk);
    rst_n <= 1'b1;
    @(negedge clk);

    // reset settings: blanks, limits, sign misuse, idle input, restart
    mark_first = 1'b1;
    push_ch(8'h0C);
    push_ch(8'h0B);
    more_text("\t\n\r -2147483648,");
    push_text("2147483648 ");
    push_text("-99999999999;");
    push_text("+-5");
    push_text("- 5");
    push_text("x");
    push_ch(8'hFF);
    push_ch(8'h00);
    push_text("12");
    push_text("34");
    push_ch(8'hFF);
    push_text("+0");

    // automatic radix: hex prefix, lone prefix, octal, zero then non-x
    set_regs(rtip_pkg::BASE_AUTO, 1'b1);
    push_text("0x1f ");
    push_text("0X7FFFFFFF.");
    push_text("0xg");
    push_text("017 ");
    push_text("09");
    push_text("-0x80000000 ");
    push_text("0");
    push_ch(8'h00);

    // hex, unsigned: negation wraps, overflow saturates to all ones
    set_regs(rtip_pkg::BASE_HEX, 1'b0);
    push_text("-1 ");
    push_text("0xffffffff0 ");
    push_text("0x ");
    push_text("Ab ");

    // radix one, top of the letter range, beyond it
    set_regs(6'd1, 1'b1);
    push_text("001 ");
    set_regs(6'd36, 1'b0);
    push_text("zZ0 ");
    set_regs(6'd63, 1'b1);
    push_text("zz9Z.");

    // random phases across register settings
    for (int p = 0; p < 10; p++) begin
      set_regs(p == 9 ? 6'($urandom_range(0, 63)) : 6'(rad_list[p]), sgn_list[p][0]);
      steady = (p == 3 || p == 7);
      if (p == 2 || p == 6) hold_requests++;
      target = queued_chars + 95;
      while (queued_chars < target) begin
        if ($urandom_range(0, 9) == 0) gen_noise();
        else gen_number(int'(radix_reg));
      end
    end

    drain();
    repeat (8) @(negedge clk);
    if (parsed_numbers.size() != 0) begin
      mismatch_count += parsed_numbers.size();
      $display("%0d parsed numbers never came out", parsed_numbers.size());
    end
    $display("parsed %0d characters, checked %0d numbers over %0d register settings",
             chars_accepted, numbers_seen, settings_used);
    $display("bad or unexpected results: %0d", mismatch_count);
    if (mismatch_count == 0) begin
      $display("SUCCESS");
    end else begin
      $display("FAILURE");
    end
    $finish;
  end

endmodule
